### rtl/uart_rb_pkg.sv
// Shared types and codes for the UART transmit/receive ring buffers.
`timescale 1ns / 1ps

package uart_rb_pkg;

  // Width of the fill fields reported in each result
  localparam int FILL_W = 4;

  // Event codes carried in the mode field
  typedef enum logic [2:0] {
    MODE_PUT      = 3'd0,
    MODE_TX_READY = 3'd1,
    MODE_RX_BYTE  = 3'd2,
    MODE_GET      = 3'd3,
    MODE_FLUSH_RX = 3'd4,
    MODE_FLUSH_TX = 3'd5
  } mode_t;

  // Control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // One input event
  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] data_byte;
  } item_t;

  // One result
  typedef struct packed {
    logic              accepted;
    logic              read_valid;
    logic [7:0]        read_byte;
    logic              line_valid;
    logic [7:0]        line_byte;
    logic [FILL_W-1:0] tx_fill;
    logic [FILL_W-1:0] rx_fill;
    logic              tx_irq_on;
    logic              dropped_oldest;
  } result_t;

  // Command to one ring
  typedef struct packed {
    logic push;   // write at tail; overwrites oldest when full
    logic pop;    // read at head; ignored when empty
    logic clear;  // reset pointers and count
  } ring_cmd_t;

  // Per-event flags held until the read data returns
  typedef struct packed {
    logic accepted;
    logic read_valid;
    logic line_valid;
    logic dropped;
  } flags_t;

endpackage

### rtl/uart_rb_ring.sv
// One byte ring: synchronous memory plus head, tail and count.
`timescale 1ns / 1ps

module uart_rb_ring
  import uart_rb_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ring_cmd_t                    cmd,
  input  logic [7:0]                   wdata,
  output logic [7:0]                   rdata,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [PTR_W-1:0] head_inc;
  logic [PTR_W-1:0] tail_inc;
  logic             full;
  logic             empty;

  assign full     = (count == CNT_W'(DEPTH));
  assign empty    = (count == '0);
  assign head_inc = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
  assign tail_inc = (tail == PTR_W'(DEPTH - 1)) ? '0 : tail + 1'b1;

  // Storage: write at tail, registered read at head
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[tail] <= wdata;
    end
    if (cmd.pop) begin
      rdata <= mem[head];
    end
  end

  // Pointers and count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (cmd.push) begin
      tail <= tail_inc;
      if (full) begin
        head <= head_inc;  // oldest byte dropped
      end else begin
        count <= count + 1'b1;
      end
    end else if (cmd.pop && !empty) begin
      head  <= head_inc;
      count <= count - 1'b1;
    end
  end

endmodule

### rtl/uart_tx_rx_ring_buffers.sv
// Top level: UART transmit and receive byte rings with one result per event.
`timescale 1ns / 1ps

// Two rings of RING_DEPTH bytes, each held in its own synchronous memory.
// Every accepted event gives exactly one result carrying both fill levels,
// the transmit interrupt enable and the event's own flags. The accept edge
// updates pointers and counts and issues the memory read; in the read state
// the registered read data is loaded into the result register once that
// register is free. The result register frees the input side, so a new event
// can be taken while a result waits, but not before the last event's read
// data has been loaded. Puts into a full transmit ring are refused
// (accepted is 0); a byte received into a full receive ring replaces the
// oldest one and sets dropped_oldest.
module uart_tx_rx_ring_buffers
  import uart_rb_pkg::*;
#(
  parameter int RING_DEPTH = 8
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);

  state_t           state;
  state_t           state_next;
  logic             accept;
  logic             out_free;
  logic             load_out;
  ring_cmd_t        tx_cmd;
  ring_cmd_t        rx_cmd;
  logic [7:0]       tx_rdata;
  logic [7:0]       rx_rdata;
  logic [CNT_W-1:0] tx_count;
  logic [CNT_W-1:0] rx_count;
  logic             tx_irq;
  logic             tx_irq_next;
  flags_t           flags;
  flags_t           flags_next;
  result_t          result_next;

  assign accept   = item_valid && item_ready;
  assign out_free = !result_valid || result_ready;

  // Event decode
  always_comb begin
    tx_cmd      = '0;
    rx_cmd      = '0;
    flags_next  = '0;
    tx_irq_next = tx_irq;
    unique case (item.mode)
      MODE_PUT: begin
        if (tx_count != CNT_W'(RING_DEPTH)) begin
          tx_cmd.push         = 1'b1;
          flags_next.accepted = 1'b1;
          tx_irq_next         = 1'b1;
        end
      end
      MODE_TX_READY: begin
        if (tx_count != '0) begin
          tx_cmd.pop            = 1'b1;
          flags_next.line_valid = 1'b1;
        end
        // ring empty after this event
        if (tx_count <= CNT_W'(1)) begin
          tx_irq_next = 1'b0;
        end
      end
      MODE_RX_BYTE: begin
        rx_cmd.push        = 1'b1;
        flags_next.dropped = (rx_count == CNT_W'(RING_DEPTH));
      end
      MODE_GET: begin
        if (rx_count != '0) begin
          rx_cmd.pop            = 1'b1;
          flags_next.read_valid = 1'b1;
        end
      end
      MODE_FLUSH_RX: rx_cmd.clear = 1'b1;
      MODE_FLUSH_TX: tx_cmd.clear = 1'b1;
      default: ;
    endcase
    if (!accept) begin
      tx_cmd = '0;
      rx_cmd = '0;
    end
  end

  uart_rb_ring #(.DEPTH(RING_DEPTH)) u_tx_ring (
    .clk   (clk),
    .rst   (rst),
    .cmd   (tx_cmd),
    .wdata (item.data_byte),
    .rdata (tx_rdata),
    .count (tx_count)
  );

  uart_rb_ring #(.DEPTH(RING_DEPTH)) u_rx_ring (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rx_cmd),
    .wdata (item.data_byte),
    .rdata (rx_rdata),
    .count (rx_count)
  );

  // Interrupt enable
  always_ff @(posedge clk) begin
    if (rst) begin
      tx_irq <= 1'b0;
    end else if (accept) begin
      tx_irq <= tx_irq_next;
    end
  end

  // Flags held while the read is in flight
  always_ff @(posedge clk) begin
    if (accept) begin
      flags <= flags_next;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept)   state_next = ST_READ;
      ST_READ: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    item_ready = 1'b0;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: item_ready = 1'b1;
      ST_READ: load_out   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Result assembly: counts and enable already show the post-event state
  always_comb begin
    result_next.accepted       = flags.accepted;
    result_next.read_valid     = flags.read_valid;
    result_next.read_byte      = flags.read_valid ? rx_rdata : 8'h00;
    result_next.line_valid     = flags.line_valid;
    result_next.line_byte      = flags.line_valid ? tx_rdata : 8'h00;
    result_next.tx_fill        = FILL_W'(tx_count);
    result_next.rx_fill        = FILL_W'(rx_count);
    result_next.tx_irq_on      = tx_irq;
    result_next.dropped_oldest = flags.dropped;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (load_out) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      result <= result_next;
    end
  end

endmodule

### rtl/uart_rb_checker.sv
// Port-level checks for the ring buffer top level, with its bind.
`timescale 1ns / 1ps

module uart_rb_checker
  import uart_rb_pkg::*;
#(
  parameter int DEPTH = 8
) (
  input logic    clk,
  input logic    rst,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  // A stalled result holds
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result changed while stalled");

  // One event sets at most one event flag
  a_one_flag: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $onehot0({result.accepted, result.read_valid,
                               result.line_valid, result.dropped_oldest}))
    else $error("more than one event flag set");

  // A stored put leaves bytes queued and the interrupt enabled
  a_put_irq: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.accepted |-> result.tx_irq_on && result.tx_fill != '0)
    else $error("accepted put without enable or fill");

  // A drop happens only at a full receive ring
  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.dropped_oldest |-> result.rx_fill == FILL_W'(DEPTH))
    else $error("drop reported below full");

  // Data bytes are zero unless their valid flag is set
  a_zero_bytes: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.read_valid || result.read_byte == 8'h00) &&
                     (result.line_valid || result.line_byte == 8'h00))
    else $error("byte without its valid flag");

endmodule

bind uart_tx_rx_ring_buffers uart_rb_checker #(.DEPTH(RING_DEPTH)) u_checker (.*);

### verif/uart_tx_rx_ring_buffers_tb.sv
// Self-checking testbench for the UART transmit/receive ring buffers.
`timescale 1ns / 1ps

module uart_tx_rx_ring_buffers_tb;
  import uart_rb_pkg::*;

  localparam int RING_DEPTH = 8;
  // Mode codes with no operation behind them
  localparam logic [2:0] MODE_SPARE_LO = 3'd6;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef enum int {
    BIAS_FILL,
    BIAS_DRAIN,
    BIAS_MIXED
  } traffic_bias_t;

  logic    clk = 1'b0;
  logic    rst = 1'b1;
  logic    item_valid = 1'b0;
  logic    item_ready;
  item_t   item = '0;
  logic    result_valid;
  logic    result_ready = 1'b0;
  result_t result;

  // Idle bursts on both sides; cleared for the closing stretch
  bit idle_on = 1'b1;
  int mismatches = 0;
  result_t pending_results[$];

  // Predicted ring contents and status
  logic [7:0] tx_bytes [RING_DEPTH];
  logic [7:0] rx_bytes [RING_DEPTH];
  int tx_rd_ptr = 0, tx_wr_ptr = 0, tx_level = 0;
  int rx_rd_ptr = 0, rx_wr_ptr = 0, rx_level = 0;
  bit irq_en = 1'b0;

  uart_tx_rx_ring_buffers #(
    .RING_DEPTH(RING_DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result      (result)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic int wrap_next(int ptr);
    return (ptr == RING_DEPTH - 1) ? 0 : ptr + 1;
  endfunction

  // Apply one event to the predicted rings and return the status it reports
  function automatic result_t step_rings(item_t ev);
    result_t r;
    r = '0;
    case (ev.mode)
      MODE_PUT: begin
        if (tx_level < RING_DEPTH) begin
          tx_bytes[tx_wr_ptr] = ev.data_byte;
          tx_wr_ptr = wrap_next(tx_wr_ptr);
          tx_level++;
          irq_en = 1'b1;
          r.accepted = 1'b1;
        end
      end
      MODE_TX_READY: begin
        if (tx_level > 0) begin
          r.line_byte = tx_bytes[tx_rd_ptr];
          r.line_valid = 1'b1;
          tx_rd_ptr = wrap_next(tx_rd_ptr);
          tx_level--;
        end
        if (tx_level == 0) irq_en = 1'b0;
      end
      MODE_RX_BYTE: begin
        rx_bytes[rx_wr_ptr] = ev.data_byte;
        rx_wr_ptr = wrap_next(rx_wr_ptr);
        // full ring: oldest unread byte is lost
        if (rx_level < RING_DEPTH) begin
          rx_level++;
        end else begin
          rx_rd_ptr = wrap_next(rx_rd_ptr);
          r.dropped_oldest = 1'b1;
        end
      end
      MODE_GET: begin
        if (rx_level > 0) begin
          r.read_byte = rx_bytes[rx_rd_ptr];
          r.read_valid = 1'b1;
          rx_rd_ptr = wrap_next(rx_rd_ptr);
          rx_level--;
        end
      end
      MODE_FLUSH_RX: begin
        rx_rd_ptr = 0;
        rx_wr_ptr = 0;
        rx_level = 0;
      end
      MODE_FLUSH_TX: begin
        tx_rd_ptr = 0;
        tx_wr_ptr = 0;
        tx_level = 0;
      end
      default: ;
    endcase
    r.tx_fill = FILL_W'(tx_level);
    r.rx_fill = FILL_W'(rx_level);
    r.tx_irq_on = irq_en;
    return r;
  endfunction

  task automatic note_mismatch(string what, int unsigned exp, int unsigned act);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: mismatch in %s: expected 0x%0h, got 0x%0h", $realtime, what, exp, act);
  endtask

  task automatic check_result(result_t got);
    result_t exp;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("%0t: result 0x%0h with none expected", $realtime, got);
      return;
    end
    exp = pending_results.pop_front();
    if (got.accepted !== exp.accepted)
      note_mismatch("accepted", exp.accepted, got.accepted);
    if (got.read_valid !== exp.read_valid)
      note_mismatch("read_valid", exp.read_valid, got.read_valid);
    if (got.read_byte !== exp.read_byte)
      note_mismatch("read_byte", exp.read_byte, got.read_byte);
    if (got.line_valid !== exp.line_valid)
      note_mismatch("line_valid", exp.line_valid, got.line_valid);
    if (got.line_byte !== exp.line_byte)
      note_mismatch("line_byte", exp.line_byte, got.line_byte);
    if (got.tx_fill !== exp.tx_fill)
      note_mismatch("tx_fill", exp.tx_fill, got.tx_fill);
    if (got.rx_fill !== exp.rx_fill)
      note_mismatch("rx_fill", exp.rx_fill, got.rx_fill);
    if (got.tx_irq_on !== exp.tx_irq_on)
      note_mismatch("tx_irq_on", exp.tx_irq_on, got.tx_irq_on);
    if (got.dropped_oldest !== exp.dropped_oldest)
      note_mismatch("dropped_oldest", exp.dropped_oldest, got.dropped_oldest);
  endtask

  // Check results first, then predict for the event taken at this edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && result_ready) check_result(result);
      if (item_valid && item_ready) pending_results.push_back(step_rings(item));
    end
  end

  // Result side: random stall bursts while idling is on
  initial begin
    while (rst) @(posedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        result_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      result_ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  // Present one event and hold it until the transfer; valid stays high after
  task automatic send_event(input logic [2:0] mode, input logic [7:0] data);
    item_t ev;
    ev.mode = mode;
    ev.data_byte = data;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    item_valid <= 1'b1;
    item <= ev;
    do @(posedge clk); while (!item_ready);
  endtask

  // Empty rings and a spare mode code
  task automatic test_empty_rings();
    send_event(MODE_GET, 8'h5A);
    send_event(MODE_TX_READY, 8'hA5);
    send_event(MODE_SPARE_HI, 8'hFF);
  endtask

  // Fill transmit ring, refused put, drain one, flush, then ready on empty
  task automatic test_tx_ring();
    send_event(MODE_PUT, 8'h00);
    send_event(MODE_PUT, 8'hFF);
    repeat (RING_DEPTH - 2) send_event(MODE_PUT, 8'($urandom_range(0, 255)));
    send_event(MODE_PUT, 8'h3C);
    send_event(MODE_TX_READY, 8'h00);
    send_event(MODE_FLUSH_TX, 8'hFF);
    send_event(MODE_TX_READY, 8'h00);
  endtask

  // Overfill receive ring so the oldest byte is dropped, read one, flush
  task automatic test_rx_ring();
    send_event(MODE_RX_BYTE, 8'h00);
    send_event(MODE_RX_BYTE, 8'hFF);
    repeat (RING_DEPTH - 1) send_event(MODE_RX_BYTE, 8'($urandom_range(0, 255)));
    send_event(MODE_GET, 8'h00);
    send_event(MODE_FLUSH_RX, 8'h00);
  endtask

  function automatic logic [2:0] pick_mode(traffic_bias_t bias);
    int r;
    int put_lim, rdy_lim, rx_lim, get_lim;
    r = $urandom_range(0, 99);
    case (bias)
      BIAS_FILL: begin
        put_lim = 35; rdy_lim = 45; rx_lim = 80; get_lim = 90;
      end
      BIAS_DRAIN: begin
        put_lim = 15; rdy_lim = 50; rx_lim = 65; get_lim = 94;
      end
      default: begin
        put_lim = 24; rdy_lim = 47; rx_lim = 70; get_lim = 93;
      end
    endcase
    if (r < put_lim) return MODE_PUT;
    if (r < rdy_lim) return MODE_TX_READY;
    if (r < rx_lim) return MODE_RX_BYTE;
    if (r < get_lim) return MODE_GET;
    if (r < 96) return MODE_FLUSH_RX;
    if (r < 98) return MODE_FLUSH_TX;
    return $urandom_range(0, 1) ? MODE_SPARE_HI : MODE_SPARE_LO;
  endfunction

  // Random traffic weighted toward filling, draining or a mix
  task automatic test_random_traffic(int n_events, traffic_bias_t bias);
    repeat (n_events) send_event(pick_mode(bias), 8'($urandom_range(0, 255)));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_rings();
    test_tx_ring();
    test_rx_ring();
    for (int p = 0; p < 6; p++) test_random_traffic(220, traffic_bias_t'(p % 3));
    idle_on = 1'b0;
    test_random_traffic(130, BIAS_MIXED);
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("[uart_tx_rx_ring_buffers] OK");
    end else begin
      $display("[uart_tx_rx_ring_buffers] ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("[uart_tx_rx_ring_buffers] ERROR");
    $finish;
  end

endmodule
